### hw/rtl/vhdl_token_scanner_unit_macros.svh
// Assertion macros for the VHDL token scanner.
// Used by vhdl_token_scanner_unit; no other dependencies.
`ifndef VHDL_TOKEN_SCANNER_UNIT_MACROS_SVH
`define VHDL_TOKEN_SCANNER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VTS_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define VTS_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/vts_pkg.sv
// Shared types, token kind codes and character classes for the VHDL token scanner.
// No dependencies.
`default_nettype none

package vts_pkg;

  localparam int KIND_W       = 5;
  localparam int POS_BITS_DEF = 24;
  localparam int LEN_BITS_DEF = 16;
  localparam int MAX_RES      = 3;

  localparam logic [KIND_W-1:0] KIND_END      = 5'd0;
  localparam logic [KIND_W-1:0] KIND_COMMENT  = 5'd1;
  localparam logic [KIND_W-1:0] KIND_AMP      = 5'd2;
  localparam logic [KIND_W-1:0] KIND_TICK     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd4;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd5;
  localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd6;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd8;
  localparam logic [KIND_W-1:0] KIND_DOT      = 5'd9;
  localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_BAR      = 5'd11;
  localparam logic [KIND_W-1:0] KIND_LBRACK   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_RBRACK   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_ARROW    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_EQ       = 5'd15;
  localparam logic [KIND_W-1:0] KIND_POW      = 5'd16;
  localparam logic [KIND_W-1:0] KIND_STAR     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_COLON    = 5'd19;
  localparam logic [KIND_W-1:0] KIND_NE       = 5'd20;
  localparam logic [KIND_W-1:0] KIND_SLASH    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_GE       = 5'd22;
  localparam logic [KIND_W-1:0] KIND_GT       = 5'd23;
  localparam logic [KIND_W-1:0] KIND_LE       = 5'd24;
  localparam logic [KIND_W-1:0] KIND_BOX      = 5'd25;
  localparam logic [KIND_W-1:0] KIND_LT       = 5'd26;
  localparam logic [KIND_W-1:0] KIND_BASIC_ID = 5'd27;
  localparam logic [KIND_W-1:0] KIND_EXT_ID   = 5'd28;
  localparam logic [KIND_W-1:0] KIND_INVALID  = 5'd29;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_TICK   = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_NBSP0  = 8'hC2;
  localparam logic [7:0] CH_NBSP1  = 8'hA0;
  localparam logic [7:0] NO_PEEK   = 8'hFF;

  typedef struct packed {
    logic              twin;
    logic [KIND_W-1:0] kind;
  } delim_t;

  typedef struct packed {
    logic       load;
    logic [1:0] count;
  } push_t;

  // Latin-1 letter test on a one- or two-byte UTF-8 sequence
  function automatic logic letter_pair(input logic [7:0] c0, input logic [7:0] c1);
    logic [10:0] cp;
    logic        ok;
    ok = 1'b1;
    cp = '0;
    if (!c0[7]) begin
      cp = {4'b0, c0[6:0]};
    end else if (c0[7:5] == 3'b110) begin
      cp = {c0[4:0], c1[5:0]};
    end else begin
      ok = 1'b0;
    end
    return ok && ((cp >= 11'h041 && cp <= 11'h05A) ||
                  (cp >= 11'h061 && cp <= 11'h07A) ||
                  (cp >= 11'h0C0 && cp <= 11'h0FF && cp != 11'h0D7 && cp != 11'h0F7));
  endfunction

  // kind zero means no delimiter
  function automatic delim_t delim_code(input logic [7:0] c, input logic [7:0] p);
    delim_t d;
    d.twin = 1'b0;
    d.kind = KIND_END;
    case (c)
      CH_AMP:    d.kind = KIND_AMP;
      CH_TICK:   d.kind = KIND_TICK;
      CH_LPAREN: d.kind = KIND_LPAREN;
      CH_RPAREN: d.kind = KIND_RPAREN;
      CH_PLUS:   d.kind = KIND_PLUS;
      CH_COMMA:  d.kind = KIND_COMMA;
      CH_MINUS:  d.kind = KIND_MINUS;
      CH_DOT:    d.kind = KIND_DOT;
      CH_SEMI:   d.kind = KIND_SEMI;
      CH_BAR:    d.kind = KIND_BAR;
      CH_LBRACK: d.kind = KIND_LBRACK;
      CH_RBRACK: d.kind = KIND_RBRACK;
      CH_EQ: begin
        d.twin = (p == CH_GT);
        d.kind = d.twin ? KIND_ARROW : KIND_EQ;
      end
      CH_STAR: begin
        d.twin = (p == CH_STAR);
        d.kind = d.twin ? KIND_POW : KIND_STAR;
      end
      CH_COLON: begin
        d.twin = (p == CH_EQ);
        d.kind = d.twin ? KIND_ASSIGN : KIND_COLON;
      end
      CH_SLASH: begin
        d.twin = (p == CH_EQ);
        d.kind = d.twin ? KIND_NE : KIND_SLASH;
      end
      CH_GT: begin
        d.twin = (p == CH_EQ);
        d.kind = d.twin ? KIND_GE : KIND_GT;
      end
      CH_LT: begin
        if (p == CH_EQ) begin
          d.twin = 1'b1;
          d.kind = KIND_LE;
        end else if (p == CH_GT) begin
          d.twin = 1'b1;
          d.kind = KIND_BOX;
        end else begin
          d.kind = KIND_LT;
        end
      end
      default: d.kind = KIND_END;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/vts_core.sv
// Scanner state and the single-pass step logic for one source byte transfer.
// Depends on vts_pkg.
`default_nettype none

module vts_core #(
  parameter int POS_BITS = vts_pkg::POS_BITS_DEF,
  parameter int LEN_BITS = vts_pkg::LEN_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    fire,
  input  wire logic [7:0]                              in_byte,
  input  wire logic                                    end_of_source,
  output vts_pkg::push_t                               push,
  output logic [vts_pkg::MAX_RES-1:0][vts_pkg::KIND_W-1:0] res_kind,
  output logic [vts_pkg::MAX_RES-1:0][POS_BITS-1:0]    res_start,
  output logic [vts_pkg::MAX_RES-1:0][LEN_BITS-1:0]    res_len,
  output logic                                         halted
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_BASIC,
    MODE_EXT,
    MODE_SKIP
  } mode_t;

  localparam logic [LEN_BITS-1:0] LenMax = {LEN_BITS{1'b1}};

  mode_t               scan_mode, scan_mode_next;
  logic [7:0]          held_byte, held_byte_next;
  logic                held_valid, held_valid_next;
  logic [POS_BITS-1:0] open_start, open_start_next;
  logic [LEN_BITS-1:0] open_len, open_len_next;
  logic [POS_BITS-1:0] byte_position, byte_position_next;
  logic                backslash_seen, backslash_seen_next;
  logic                halted_next;

  logic [1:0]          n;
  logic                go_idle;
  logic [7:0]          c, p;
  logic [POS_BITS-1:0] hpos;
  vts_pkg::delim_t     dl;

  always_comb begin
    scan_mode_next      = scan_mode;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    open_start_next     = open_start;
    open_len_next       = open_len;
    byte_position_next  = byte_position;
    backslash_seen_next = backslash_seen;
    halted_next         = halted;
    res_kind            = '0;
    res_start           = '0;
    res_len             = '0;
    n                   = 2'd0;
    go_idle             = 1'b0;
    c                   = held_byte;
    p                   = end_of_source ? vts_pkg::NO_PEEK : in_byte;
    hpos                = byte_position - {{(POS_BITS-1){1'b0}}, 1'b1};
    dl                  = vts_pkg::delim_code(c, p);

    if (!halted) begin
      if (held_valid) begin
        case (scan_mode)
          MODE_SKIP: scan_mode_next = MODE_IDLE;
          MODE_COMMENT: begin
            if (c != vts_pkg::CH_LF) begin
              if (open_len != LenMax) open_len_next = open_len + 1'b1;
            end else begin
              res_kind[n]    = vts_pkg::KIND_COMMENT;
              res_start[n]   = open_start;
              res_len[n]     = open_len;
              n              = n + 2'd1;
              scan_mode_next = MODE_IDLE;
              go_idle        = 1'b1;
            end
          end
          MODE_BASIC: begin
            if (c[7:6] == 2'b10 || vts_pkg::letter_pair(c, p) ||
                (c >= vts_pkg::CH_ZERO && c <= vts_pkg::CH_NINE) ||
                c == vts_pkg::CH_UNDER) begin
              if (open_len != LenMax) open_len_next = open_len + 1'b1;
            end else begin
              res_kind[n]    = vts_pkg::KIND_BASIC_ID;
              res_start[n]   = open_start;
              res_len[n]     = open_len;
              n              = n + 2'd1;
              scan_mode_next = MODE_IDLE;
              go_idle        = 1'b1;
            end
          end
          MODE_EXT: begin
            if (open_len != LenMax) open_len_next = open_len + 1'b1;
            if (backslash_seen) begin
              backslash_seen_next = 1'b0;
            end else if (c == vts_pkg::CH_BSLASH) begin
              if (p == vts_pkg::CH_BSLASH) begin
                backslash_seen_next = 1'b1;
              end else begin
                res_kind[n]    = vts_pkg::KIND_EXT_ID;
                res_start[n]   = open_start;
                res_len[n]     = open_len_next;
                n              = n + 2'd1;
                scan_mode_next = MODE_IDLE;
              end
            end
          end
          default: go_idle = 1'b1;
        endcase

        if (go_idle) begin
          if (c == vts_pkg::CH_SPACE || c == vts_pkg::CH_LF ||
              c == vts_pkg::CH_TAB || c == vts_pkg::CH_CR) begin
            scan_mode_next = MODE_IDLE;
          end else if (c == vts_pkg::CH_NBSP0 && p == vts_pkg::CH_NBSP1) begin
            scan_mode_next = MODE_SKIP;
          end else if (c == vts_pkg::CH_MINUS && p == vts_pkg::CH_MINUS) begin
            scan_mode_next  = MODE_COMMENT;
            open_start_next = hpos;
            open_len_next   = {{(LEN_BITS-1){1'b0}}, 1'b1};
          end else if (dl.kind != vts_pkg::KIND_END) begin
            res_kind[n]    = dl.kind;
            res_start[n]   = hpos;
            res_len[n]     = dl.twin ? LEN_BITS'(2) : LEN_BITS'(1);
            n              = n + 2'd1;
            scan_mode_next = dl.twin ? MODE_SKIP : MODE_IDLE;
          end else if (vts_pkg::letter_pair(c, p)) begin
            scan_mode_next  = MODE_BASIC;
            open_start_next = hpos;
            open_len_next   = {{(LEN_BITS-1){1'b0}}, 1'b1};
          end else if (c == vts_pkg::CH_BSLASH) begin
            scan_mode_next      = MODE_EXT;
            open_start_next     = hpos;
            open_len_next       = {{(LEN_BITS-1){1'b0}}, 1'b1};
            backslash_seen_next = 1'b0;
          end else begin
            res_kind[n]  = vts_pkg::KIND_INVALID;
            res_start[n] = hpos;
            res_len[n]   = {{(LEN_BITS-1){1'b0}}, 1'b1};
            n            = n + 2'd1;
            halted_next  = 1'b1;
          end
        end
      end

      if (!end_of_source) begin
        held_byte_next     = in_byte;
        held_valid_next    = 1'b1;
        byte_position_next = byte_position + {{(POS_BITS-1){1'b0}}, 1'b1};
      end else if (!halted_next) begin
        case (scan_mode_next)
          MODE_COMMENT: begin
            res_kind[n]  = vts_pkg::KIND_COMMENT;
            res_start[n] = open_start_next;
            res_len[n]   = open_len_next;
            n            = n + 2'd1;
          end
          MODE_BASIC: begin
            res_kind[n]  = vts_pkg::KIND_BASIC_ID;
            res_start[n] = open_start_next;
            res_len[n]   = open_len_next;
            n            = n + 2'd1;
          end
          MODE_EXT: begin
            res_kind[n]  = vts_pkg::KIND_EXT_ID;
            res_start[n] = open_start_next;
            res_len[n]   = open_len_next;
            n            = n + 2'd1;
          end
          default: n = n;
        endcase
        // a fourth token would not fit, the end token is then dropped
        if (n != 2'd3) begin
          res_kind[n]  = vts_pkg::KIND_END;
          res_start[n] = byte_position;
          res_len[n]   = '0;
          n            = n + 2'd1;
        end
        scan_mode_next      = MODE_IDLE;
        held_byte_next      = '0;
        held_valid_next     = 1'b0;
        open_start_next     = '0;
        open_len_next       = '0;
        byte_position_next  = '0;
        backslash_seen_next = 1'b0;
      end
    end

    push.count = n;
    push.load  = fire && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= MODE_IDLE;
      held_byte      <= '0;
      held_valid     <= 1'b0;
      open_start     <= '0;
      open_len       <= '0;
      byte_position  <= '0;
      backslash_seen <= 1'b0;
      halted         <= 1'b0;
    end else if (fire) begin
      scan_mode      <= scan_mode_next;
      held_byte      <= held_byte_next;
      held_valid     <= held_valid_next;
      open_start     <= open_start_next;
      open_len       <= open_len_next;
      byte_position  <= byte_position_next;
      backslash_seen <= backslash_seen_next;
      halted         <= halted_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vts_outbuf.sv
// Result register: holds the up to three tokens of one step and drains them in order.
// Depends on vts_pkg.
`default_nettype none

module vts_outbuf #(
  parameter int POS_BITS = vts_pkg::POS_BITS_DEF,
  parameter int LEN_BITS = vts_pkg::LEN_BITS_DEF,
  parameter int TDATA_W  = 48
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire vts_pkg::push_t                               push,
  input  wire logic [vts_pkg::MAX_RES-1:0][vts_pkg::KIND_W-1:0] res_kind,
  input  wire logic [vts_pkg::MAX_RES-1:0][POS_BITS-1:0]    res_start,
  input  wire logic [vts_pkg::MAX_RES-1:0][LEN_BITS-1:0]    res_len,
  output logic                                              space,
  output logic                                              m_tvalid,
  input  wire logic                                         m_tready,
  output logic [TDATA_W-1:0]                                m_tdata,
  output logic                                              m_tlast
);

  logic [vts_pkg::MAX_RES-1:0][vts_pkg::KIND_W-1:0] kind_q;
  logic [vts_pkg::MAX_RES-1:0][POS_BITS-1:0]        start_q;
  logic [vts_pkg::MAX_RES-1:0][LEN_BITS-1:0]        len_q;
  logic [1:0] remaining;
  logic [1:0] idx;
  logic       pop;

  assign m_tvalid = (remaining != 2'd0);
  assign m_tlast  = (remaining == 2'd1);
  assign pop      = m_tvalid && m_tready;
  assign space    = (remaining == 2'd0) || (remaining == 2'd1 && m_tready);
  assign m_tdata  = TDATA_W'({len_q[idx], start_q[idx], kind_q[idx]});

  always_ff @(posedge clk) begin
    if (push.load) begin
      kind_q  <= res_kind;
      start_q <= res_start;
      len_q   <= res_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      idx       <= 2'd0;
    end else if (push.load) begin
      remaining <= push.count;
      idx       <= 2'd0;
    end else if (pop) begin
      remaining <= remaining - 2'd1;
      idx       <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/vhdl_token_scanner_unit.sv
// Top level of the VHDL token scanner: input register, step logic, result register.
// Depends on vts_pkg, vts_core, vts_outbuf and vhdl_token_scanner_unit_macros.svh.
// The first token of a step is on m_* from the result register, loaded when the step fires.
// Throughput: one source byte per cycle while the result register has space; a step with
// several tokens stalls the input until its last token is taken, one token per cycle on m_tready.
// Reset (rst, synchronous): empties both registers and returns scan state to offset 0.
`default_nettype none

`include "vhdl_token_scanner_unit_macros.svh"

module vhdl_token_scanner_unit #(
  parameter int POS_BITS = vts_pkg::POS_BITS_DEF,
  parameter int LEN_BITS = vts_pkg::LEN_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic [7:0] s_tdata,  // [7:0] in_byte
  input  wire logic s_tuser,        // end_of_source
  output logic      m_tvalid,
  input  wire logic m_tready,
  output logic [((vts_pkg::KIND_W+POS_BITS+LEN_BITS+7)/8)*8-1:0] m_tdata,
  // m_tdata from bit 0: token_kind, token_start, token_length, zero pad
  output logic      m_tlast         // last_of_run
);

  localparam int TDATA_W = ((vts_pkg::KIND_W + POS_BITS + LEN_BITS + 7) / 8) * 8;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       fire;
  logic       space;
  logic       halted;

  vts_pkg::push_t push;
  logic [vts_pkg::MAX_RES-1:0][vts_pkg::KIND_W-1:0] res_kind;
  logic [vts_pkg::MAX_RES-1:0][POS_BITS-1:0]        res_start;
  logic [vts_pkg::MAX_RES-1:0][LEN_BITS-1:0]        res_len;

  assign fire     = in_valid && space;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eos  <= s_tuser;
    end
  end

  vts_core #(
    .POS_BITS(POS_BITS),
    .LEN_BITS(LEN_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .in_byte      (in_byte),
    .end_of_source(in_eos),
    .push         (push),
    .res_kind     (res_kind),
    .res_start    (res_start),
    .res_len      (res_len),
    .halted       (halted)
  );

  vts_outbuf #(
    .POS_BITS(POS_BITS),
    .LEN_BITS(LEN_BITS),
    .TDATA_W (TDATA_W)
  ) u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res_kind (res_kind),
    .res_start(res_start),
    .res_len  (res_len),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // once halted, only reset clears it
  `VTS_ASSERT_NXT(a_halt_sticky, clk, rst, halted, halted, "halt flag dropped")
  // a byte transfer never yields three tokens
  `VTS_ASSERT_IMP(a_byte_max2, clk, rst, fire && !in_eos, push.count != 2'd3, "three tokens")
  // end of source always yields at least one token unless halted
  `VTS_ASSERT_IMP(a_eos_end, clk, rst, fire && in_eos && !halted, push.count != 2'd0, "no token")

endmodule

`default_nettype wire

### tb/sv/vts_tb_pkg.sv
// Token scoreboard for the VHDL token scanner testbench: predicts the tokens of each
// accepted source byte and checks the tokens the block emits against them.
// Depends on vts_pkg for token kind codes, character codes and widths.
package vts_tb_pkg;
  import vts_pkg::*;

  localparam int POS_W   = POS_BITS_DEF;
  localparam int LEN_W   = LEN_BITS_DEF;
  localparam int TDATA_W = ((KIND_W + POS_W + LEN_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_COMMENT, SCAN_BASIC, SCAN_EXT, SCAN_SKIP
  } scan_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic              last;
  } token_t;

  class token_scoreboard;
    scan_e            mode;
    logic [7:0]       held;
    bit               held_ok;
    logic [POS_W-1:0] tok_start;
    logic [POS_W-1:0] next_pos;
    logic [LEN_W-1:0] tok_len;
    bit               escaped;
    bit               halted;
    token_t           step_q[$];
    token_t           expected_tokens[$];
    int               errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      mode      = SCAN_IDLE;
      held      = '0;
      held_ok   = 1'b0;
      tok_start = '0;
      next_pos  = '0;
      tok_len   = '0;
      escaped   = 1'b0;
      halted    = 1'b0;
    endfunction

    function bit busy();
      return expected_tokens.size() != 0;
    endfunction

    // Latin-1 letter, given as one byte or as a two-byte UTF-8 sequence
    function bit latin_letter(logic [7:0] c0, logic [7:0] c1);
      logic [10:0] cp;
      if (!c0[7]) begin
        cp = {4'b0, c0[6:0]};
      end else if (c0[7:5] == 3'b110) begin
        cp = {c0[4:0], c1[5:0]};
      end else begin
        return 1'b0;
      end
      return (cp >= 11'h041 && cp <= 11'h05A) || (cp >= 11'h061 && cp <= 11'h07A) ||
             (cp >= 11'h0C0 && cp <= 11'h0FF && cp != 11'h0D7 && cp != 11'h0F7);
    endfunction

    function void add_token(logic [KIND_W-1:0] kind, logic [POS_W-1:0] start,
                            logic [LEN_W-1:0] len);
      if (step_q.size() < MAX_RES) step_q.push_back('{kind, start, len, 1'b0});
    endfunction

    function void open_tok(scan_e m, logic [POS_W-1:0] at);
      mode      = m;
      tok_start = at;
      tok_len   = LEN_W'(1);
    endfunction

    function void grow();
      if (tok_len != {LEN_W{1'b1}}) tok_len = tok_len + 1'b1;
    endfunction

    // byte c seen between tokens, p is the lookahead
    function void scan_fresh(logic [7:0] c, logic [POS_W-1:0] at, logic [7:0] p);
      logic [KIND_W-1:0] kind;
      bit                twin;
      twin = 1'b0;
      kind = KIND_END;
      if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR) return;
      if (c == CH_NBSP0 && p == CH_NBSP1) begin
        mode = SCAN_SKIP;
        return;
      end
      if (c == CH_MINUS && p == CH_MINUS) begin
        open_tok(SCAN_COMMENT, at);
        return;
      end
      case (c)
        CH_AMP:    kind = KIND_AMP;
        CH_TICK:   kind = KIND_TICK;
        CH_LPAREN: kind = KIND_LPAREN;
        CH_RPAREN: kind = KIND_RPAREN;
        CH_PLUS:   kind = KIND_PLUS;
        CH_COMMA:  kind = KIND_COMMA;
        CH_MINUS:  kind = KIND_MINUS;
        CH_DOT:    kind = KIND_DOT;
        CH_SEMI:   kind = KIND_SEMI;
        CH_BAR:    kind = KIND_BAR;
        CH_LBRACK: kind = KIND_LBRACK;
        CH_RBRACK: kind = KIND_RBRACK;
        CH_EQ: begin
          twin = (p == CH_GT);
          kind = twin ? KIND_ARROW : KIND_EQ;
        end
        CH_STAR: begin
          twin = (p == CH_STAR);
          kind = twin ? KIND_POW : KIND_STAR;
        end
        CH_COLON: begin
          twin = (p == CH_EQ);
          kind = twin ? KIND_ASSIGN : KIND_COLON;
        end
        CH_SLASH: begin
          twin = (p == CH_EQ);
          kind = twin ? KIND_NE : KIND_SLASH;
        end
        CH_GT: begin
          twin = (p == CH_EQ);
          kind = twin ? KIND_GE : KIND_GT;
        end
        CH_LT: begin
          twin = (p == CH_EQ || p == CH_GT);
          kind = (p == CH_EQ) ? KIND_LE : (p == CH_GT) ? KIND_BOX : KIND_LT;
        end
        default: ;
      endcase
      if (kind != KIND_END) begin
        add_token(kind, at, twin ? LEN_W'(2) : LEN_W'(1));
        if (twin) mode = SCAN_SKIP;
        return;
      end
      if (latin_letter(c, p)) begin
        open_tok(SCAN_BASIC, at);
        return;
      end
      if (c == CH_BSLASH) begin
        open_tok(SCAN_EXT, at);
        escaped = 1'b0;
        return;
      end
      add_token(KIND_INVALID, at, LEN_W'(1));
      halted = 1'b1;
    endfunction

    // held byte c decided once its lookahead p is known
    function void scan_held(logic [7:0] c, logic [POS_W-1:0] at, logic [7:0] p);
      case (mode)
        SCAN_SKIP: begin
          mode = SCAN_IDLE;
          return;
        end
        SCAN_COMMENT: begin
          if (c != CH_LF) begin
            grow();
            return;
          end
          add_token(KIND_COMMENT, tok_start, tok_len);
          mode = SCAN_IDLE;
        end
        SCAN_BASIC: begin
          if (c[7:6] == 2'b10 || latin_letter(c, p) || (c >= CH_ZERO && c <= CH_NINE) ||
              c == CH_UNDER) begin
            grow();
            return;
          end
          add_token(KIND_BASIC_ID, tok_start, tok_len);
          mode = SCAN_IDLE;
        end
        SCAN_EXT: begin
          grow();
          if (escaped) begin
            escaped = 1'b0;
            return;
          end
          if (c == CH_BSLASH) begin
            if (p == CH_BSLASH) begin
              escaped = 1'b1;
              return;
            end
            add_token(KIND_EXT_ID, tok_start, tok_len);
            mode = SCAN_IDLE;
          end
          return;
        end
        default: mode = SCAN_IDLE;
      endcase
      scan_fresh(c, at, p);
    endfunction

    function void note_byte(logic [7:0] b, logic eos);
      logic [POS_W-1:0] held_at;
      if (halted) return;
      step_q.delete();
      held_at = next_pos - 1'b1;
      if (!eos) begin
        if (held_ok) scan_held(held, held_at, b);
        held     = b;
        held_ok  = 1'b1;
        next_pos = next_pos + 1'b1;
      end else begin
        if (held_ok) scan_held(held, held_at, NO_PEEK);
        if (!halted) begin
          case (mode)
            SCAN_COMMENT: add_token(KIND_COMMENT, tok_start, tok_len);
            SCAN_BASIC:   add_token(KIND_BASIC_ID, tok_start, tok_len);
            SCAN_EXT:     add_token(KIND_EXT_ID, tok_start, tok_len);
            default: ;
          endcase
          add_token(KIND_END, next_pos, '0);
          restart();
        end
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) expected_tokens.push_back(step_q[i]);
    endfunction

    function void check_token(logic [TDATA_W-1:0] data, logic last);
      token_t           want;
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  start;
      logic [LEN_W-1:0]  len;
      kind  = data[KIND_W-1:0];
      start = data[KIND_W +: POS_W];
      len   = data[KIND_W+POS_W +: LEN_W];
      if (expected_tokens.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token: kind %0d start %0d len %0d last %0b",
                   kind, start, len, last);
        return;
      end
      want = expected_tokens.pop_front();
      if (want.kind !== kind || want.start !== start || want.len !== len ||
          want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display({"token mismatch: expected kind %0d start %0d len %0d last %0b, ",
                    "got kind %0d start %0d len %0d last %0b"},
                   want.kind, want.start, want.len, want.last, kind, start, len, last);
      end
    endfunction
  endclass

endpackage

### tb/sv/tb_top.sv
// Top-level testbench for vhdl_token_scanner_unit: streams directed and random VHDL
// source bytes with random stalls on both sides and checks every token.
// Depends on vts_pkg, vts_tb_pkg and the scanner RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vts_pkg::*;
  import vts_tb_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_BYTES = 60;

  localparam logic [7:0] LATIN1_LEAD = 8'hC3;
  localparam logic [7:0] TIMES_TAIL  = 8'h97;
  localparam logic [7:0] DIVIDE_TAIL = 8'hB7;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;  // [7:0] in_byte
  logic               s_tuser;  // end_of_source
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;  // token_kind, token_start, token_length, zero pad
  logic               m_tlast;  // last_of_run

  token_scoreboard sb;
  bit              tx_gaps;
  bit              rx_gaps;
  bit              hold_req;
  logic [7:0]      text_q[$];
  int              quiet;

  // a lone minus is followed by a space so that two never merge into a comment
  string delim_set[25] = '{"&", "'", "(", ")", "+", ",", "- ", ".", ";", "|", "[", "]",
                           "=", "=>", "*", "**", ":", ":=", "/", "/=", ">", ">=",
                           "<", "<=", "<>"};

  vhdl_token_scanner_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic push_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= eos ? 8'($urandom) : b;
    s_tuser  <= eos;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_text(input bit with_end);
    foreach (text_q[i]) push_item(text_q[i], 1'b0);
    if (with_end) push_item(8'h00, 1'b1);
    text_q.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.busy()) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_letter();
    int         r;
    logic [7:0] t;
    r = $urandom_range(0, 2);
    if (r == 0) begin
      text_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
    end else if (r == 1) begin
      text_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
    end else begin
      do t = 8'($urandom_range(CONT_LO, CONT_HI)); while (t == TIMES_TAIL || t == DIVIDE_TAIL);
      text_q.push_back(LATIN1_LEAD);
      text_q.push_back(t);
    end
  endtask

  // opening backslash and content, no closing one
  task automatic add_ext_body();
    int         n;
    logic [7:0] t;
    text_q.push_back(CH_BSLASH);
    n = $urandom_range(0, 6);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_BSLASH);
      end else begin
        do t = 8'($urandom); while (t == CH_BSLASH);
        text_q.push_back(t);
      end
    end
  endtask

  task automatic add_comment_body(input int n);
    logic [7:0] t;
    text_q.push_back(CH_MINUS);
    text_q.push_back(CH_MINUS);
    repeat (n) begin
      do t = 8'($urandom); while (t == CH_LF);
      text_q.push_back(t);
    end
  endtask

  task automatic add_token();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0: text_q.push_back(CH_SPACE);
          1: text_q.push_back(CH_TAB);
          2: text_q.push_back(CH_CR);
          3: text_q.push_back(CH_LF);
          default: begin
            text_q.push_back(CH_NBSP0);
            text_q.push_back(CH_NBSP1);
          end
        endcase
      end
      2, 3, 4: add_text(delim_set[$urandom_range(0, 24)]);
      5, 6, 7: begin
        add_letter();
        n = $urandom_range(0, 6);
        repeat (n) begin
          case ($urandom_range(0, 4))
            1: text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            2: text_q.push_back(CH_UNDER);
            3: text_q.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
            default: add_letter();
          endcase
        end
      end
      8: begin
        add_ext_body();
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_SPACE);
      end
      default: begin
        add_comment_body($urandom_range(0, 8));
        text_q.push_back(CH_LF);
      end
    endcase
  endtask

  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = rx_gaps ? $urandom_range(0, 17) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // transfer monitor and watchdog
  initial begin
    bit moved;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      moved = 1'b0;
      if (m_tvalid === 1'b1 && m_tready) begin
        sb.check_token(m_tdata, m_tlast);
        moved = 1'b1;
      end
      if (s_tvalid && s_tready === 1'b1) begin
        sb.note_byte(s_tdata, s_tuser);
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int         random_sent;
    int         n_tok;
    logic [7:0] bad;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_req = 1'b0;
    sb       = new();
    repeat (3) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // twin and single less-than, nbsp, comment with extreme bytes, Latin-1 id,
    // extended id with an escaped backslash closed against the missing lookahead
    add_text("<=<>< ");
    text_q.push_back(CH_NBSP0);
    text_q.push_back(CH_NBSP1);
    add_text("--");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    text_q.push_back(CH_LF);
    text_q.push_back(LATIN1_LEAD);
    text_q.push_back(CONT_LO);
    add_text("_9");
    text_q.push_back(CONT_LO);
    add_text(" \\a\\\\\\");
    send_text(1'b1);
    // lead byte read as a letter against a space as lookahead, then unclosed ext id
    add_text("a");
    text_q.push_back(LATIN1_LEAD);
    add_text(" \\z");
    send_text(1'b1);
    send_text(1'b1);

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      if (random_sent == 0) begin
        hold_req = 1'b1;
        tx_gaps  = 1'b0;
        n_tok    = 12;
      end else begin
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_gaps = $urandom_range(0, 3) != 0;
        n_tok   = $urandom_range(0, 12);
      end
      repeat (n_tok) add_token();
      case ($urandom_range(0, 5))
        0: add_ext_body();
        1: add_comment_body($urandom_range(0, 5));
        2: add_text(delim_set[$urandom_range(0, 24)]);
        default: ;
      endcase
      random_sent += text_q.size() + 1;
      send_text(1'b1);
    end

    // invalid byte halts the scanner until reset, end of source included
    wait_drained();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    case ($urandom_range(0, 3))
      0: bad = 8'h00;
      1: bad = 8'(CH_ZERO + $urandom_range(0, 9));
      2: bad = 8'($urandom_range(CONT_LO, CONT_HI));
      default: bad = 8'hFF;
    endcase
    add_text("x ");
    text_q.push_back(bad);
    add_text(" ab;");
    send_text(1'b1);
    add_text("c<=");
    send_text(1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && !sb.busy()) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/vts_pkg.sv
hw/rtl/vts_core.sv
hw/rtl/vts_outbuf.sv
hw/rtl/vhdl_token_scanner_unit.sv
tb/sv/vts_tb_pkg.sv
tb/sv/tb_top.sv
